### src/periodic_task_tick_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Periodic task tick scheduler - assertion macros
// Concurrent assertion wrappers on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define PTTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptts: same-cycle check failed");

// Next-cycle implication.
`define PTTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptts: next-cycle check failed");

`endif

### src/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared sizes, action codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

  localparam int TASK_COUNT  = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int TASK_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  // Fixed widths of the beat fields
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 3;
  localparam int TICKS_W  = 16;

  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SUSPEND = 2'd2;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WALK,
    SEQ_FLUSH
  } seq_state_e;

  // Write command into the task table
  typedef struct packed {
    logic                   load;
    logic                   suspend;
    logic                   cnt_we;
    logic [TASK_W-1:0]      idx;
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] count;
  } tbl_cmd_t;

  // Read data of the walked task
  typedef struct packed {
    logic                   ready;
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] period;
  } tbl_rd_t;

  // Result push into the output register
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } out_push_t;

endpackage

`default_nettype wire

### src/ptts_task_table.sv
// ----------------------------------------------------------------------------
// ptts_task_table
// Per-task ready flags, periods and countdowns; one read port, one write.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_task_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ptts_pkg::tbl_cmd_t        cmd_i,
  input  wire logic [ptts_pkg::TASK_W-1:0] rd_idx_i,
  output ptts_pkg::tbl_rd_t              rd_o
);

  logic [ptts_pkg::TASK_COUNT-1:0]  ready_q;
  logic [ptts_pkg::COUNT_WIDTH-1:0] period_q [ptts_pkg::TASK_COUNT];
  logic [ptts_pkg::COUNT_WIDTH-1:0] count_q  [ptts_pkg::TASK_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= '0;
    end else if (cmd_i.load) begin
      ready_q[cmd_i.idx] <= 1'b1;
    end else if (cmd_i.suspend) begin
      ready_q[cmd_i.idx] <= 1'b0;
    end
  end

  // Period and countdown start undefined; only read once loaded
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      period_q[cmd_i.idx] <= cmd_i.period;
      count_q[cmd_i.idx]  <= cmd_i.count;
    end else if (cmd_i.cnt_we) begin
      count_q[cmd_i.idx]  <= cmd_i.count;
    end
  end

  assign rd_o.ready  = ready_q[rd_idx_i];
  assign rd_o.count  = count_q[rd_idx_i];
  assign rd_o.period = period_q[rd_idx_i];

endmodule

`default_nettype wire

### src/ptts_out_stage.sv
// ----------------------------------------------------------------------------
// ptts_out_stage
// Output register for fired-task beats; frees its slot when taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_out_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ptts_pkg::out_push_t          push_i,
  output logic                              slot_free_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ptts_pkg::INDEX_W-1:0]      fired_task_o,
  output logic                              last_of_tick_o
);

  logic                          valid_q, valid_d;
  logic [ptts_pkg::INDEX_W-1:0]  fired_q;
  logic                          last_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i.valid) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      fired_q <= push_i.idx;
      last_q  <= push_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign fired_task_o   = fired_q;
  assign last_of_tick_o = last_q;

endmodule

`default_nettype wire

### src/ptts_sequencer.sv
// ----------------------------------------------------------------------------
// ptts_sequencer
// Decodes input beats and walks the table one task a cycle on a tick, waiting while the output slot is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_tick_scheduler_macros.svh"

module ptts_sequencer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [ptts_pkg::ACTION_W-1:0]    action_i,
  input  wire logic [ptts_pkg::INDEX_W-1:0]     task_index_i,
  input  wire logic [ptts_pkg::TICKS_W-1:0]     period_ticks_i,
  input  wire logic [ptts_pkg::TICKS_W-1:0]     first_delay_ticks_i,
  input  wire ptts_pkg::tbl_rd_t                rd_i,
  output logic [ptts_pkg::TASK_W-1:0]           rd_idx_o,
  output ptts_pkg::tbl_cmd_t                    cmd_o,
  input  wire logic                             slot_free_i,
  output ptts_pkg::out_push_t                   push_o
);

  localparam logic [ptts_pkg::TASK_W-1:0] LastIdx = ptts_pkg::TASK_W'(ptts_pkg::TASK_COUNT - 1);

  ptts_pkg::seq_state_e            state_q, state_d;
  logic [ptts_pkg::TASK_W-1:0]     walk_q, walk_d;
  logic [ptts_pkg::TASK_W-1:0]     pend_q, pend_d;
  logic                            have_pend_q, have_pend_d;

  logic                            accept;
  logic                            tick_go;
  logic                            walk_exit;
  logic                            idx_ok;
  logic                            fire;
  logic                            need_push;
  logic                            step;
  logic                            done;
  logic [ptts_pkg::COUNT_WIDTH-1:0] base;
  logic [ptts_pkg::COUNT_WIDTH-1:0] period_in;

  assign accept    = in_valid_i && !in_stall_o;
  assign tick_go   = accept && (action_i == ptts_pkg::ACT_TICK);
  assign idx_ok    = 32'(task_index_i) < 32'(ptts_pkg::TASK_COUNT);
  assign period_in = ptts_pkg::COUNT_WIDTH'(period_ticks_i);
  assign rd_idx_o  = walk_q;

  // Shared unit: zero compare, reload select, decrement
  assign fire = rd_i.ready && (rd_i.count == '0);
  assign base = fire ? rd_i.period : rd_i.count;

  assign need_push = (state_q == ptts_pkg::SEQ_WALK) ? (fire && have_pend_q) : have_pend_q;
  assign step      = !need_push || slot_free_i;
  assign done      = !have_pend_q || slot_free_i;
  assign walk_exit = (state_q == ptts_pkg::SEQ_WALK) && step && (walk_q == LastIdx);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptts_pkg::SEQ_IDLE: begin
        if (tick_go) begin
          state_d = ptts_pkg::SEQ_WALK;
        end
      end
      ptts_pkg::SEQ_WALK: begin
        if (walk_exit) begin
          state_d = ptts_pkg::SEQ_FLUSH;
        end
      end
      ptts_pkg::SEQ_FLUSH: begin
        if (done) begin
          state_d = ptts_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = ptts_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    push_o      = '0;
    walk_d      = walk_q;
    pend_d      = pend_q;
    have_pend_d = have_pend_q;
    unique case (state_q)
      ptts_pkg::SEQ_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.idx  = ptts_pkg::TASK_W'(task_index_i);
        if (in_valid_i) begin
          unique case (action_i)
            ptts_pkg::ACT_TICK: begin
              walk_d      = '0;
              have_pend_d = 1'b0;
            end
            ptts_pkg::ACT_LOAD: begin
              cmd_o.load   = idx_ok;
              cmd_o.period = (period_in == '0) ? ptts_pkg::COUNT_WIDTH'(1) : period_in;
              cmd_o.count  = ptts_pkg::COUNT_WIDTH'(first_delay_ticks_i);
            end
            ptts_pkg::ACT_SUSPEND: begin
              cmd_o.suspend = idx_ok;
            end
            default: begin
            end
          endcase
        end
      end
      ptts_pkg::SEQ_WALK: begin
        cmd_o.idx   = walk_q;
        cmd_o.count = base - ptts_pkg::COUNT_WIDTH'(1);
        if (step) begin
          cmd_o.cnt_we = rd_i.ready;
          push_o.valid = need_push;
          push_o.idx   = ptts_pkg::INDEX_W'(pend_q);
          push_o.last  = 1'b0;
          if (fire) begin
            pend_d      = walk_q;
            have_pend_d = 1'b1;
          end
          if (walk_q != LastIdx) begin
            walk_d = walk_q + ptts_pkg::TASK_W'(1);
          end
        end
      end
      ptts_pkg::SEQ_FLUSH: begin
        push_o.valid = have_pend_q && slot_free_i;
        push_o.idx   = ptts_pkg::INDEX_W'(pend_q);
        push_o.last  = 1'b1;
        if (done) begin
          have_pend_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptts_pkg::SEQ_IDLE;
      walk_q      <= '0;
      have_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      have_pend_q <= have_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // A closing beat only leaves from the flush step
  `PTTS_ASSERT_NOW(a_last_only_in_flush, push_o.valid && push_o.last, state_q == ptts_pkg::SEQ_FLUSH)
  // Never push over a beat that is still waiting
  `PTTS_ASSERT_NOW(a_push_has_slot, push_o.valid, slot_free_i)
  // Stepping past the last task ends the walk
  `PTTS_ASSERT_NEXT(a_walk_ends, walk_exit, state_q == ptts_pkg::SEQ_FLUSH)
  // A tick starts with nothing pending
  `PTTS_ASSERT_NEXT(a_tick_clean, tick_go, !have_pend_q && walk_q == '0)

endmodule

`default_nettype wire

### src/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered cooperative scheduler: fires due periodic tasks on each tick.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake                Beat fields
//   -------  ---  -----------------------  ---------------------------------
//   in       in   in_valid_i/in_stall_o    action, task_index, period_ticks,
//                                          first_delay_ticks
//   out      out  out_valid_o/out_stall_i  fired_task, last_of_tick
//
// Load and suspend beats may follow back to back. A tick is accepted, then
// walks one task per cycle through the shared countdown unit, pausing while a
// result waits for a free output slot, and ends with one flush step.
// Reset clears the ready flags and the sequencer; periods and countdowns are
// left as they are and only read after a load.
// out_stall_i holds the output register; the walk waits for a free slot.
//
`default_nettype none

module periodic_task_tick_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ptts_pkg::ACTION_W-1:0] action_i,
  input  wire logic [ptts_pkg::INDEX_W-1:0]  task_index_i,
  input  wire logic [ptts_pkg::TICKS_W-1:0]  period_ticks_i,
  input  wire logic [ptts_pkg::TICKS_W-1:0]  first_delay_ticks_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ptts_pkg::INDEX_W-1:0]       fired_task_o,
  output logic                               last_of_tick_o
);

  ptts_pkg::tbl_cmd_t          tbl_cmd;
  ptts_pkg::tbl_rd_t           tbl_rd;
  logic [ptts_pkg::TASK_W-1:0] tbl_rd_idx;
  ptts_pkg::out_push_t         out_push;
  logic                        slot_free;

  // Task table: ready flags, periods and countdowns
  ptts_task_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (tbl_cmd),
    .rd_idx_i (tbl_rd_idx),
    .rd_o     (tbl_rd)
  );

  // Decode beats, walk the table, hold back one fired task so that the
  // final one of a tick can be marked as last
  ptts_sequencer u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .task_index_i        (task_index_i),
    .period_ticks_i      (period_ticks_i),
    .first_delay_ticks_i (first_delay_ticks_i),
    .rd_i                (tbl_rd),
    .rd_idx_o            (tbl_rd_idx),
    .cmd_o               (tbl_cmd),
    .slot_free_i         (slot_free),
    .push_o              (out_push)
  );

  // Output register: hold a result beat until it is taken
  ptts_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (out_push),
    .slot_free_o    (slot_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fired_task_o   (fired_task_o),
    .last_of_tick_o (last_of_tick_o)
  );

endmodule

`default_nettype wire

### tb/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler
// Self-checking bench for the tick scheduler. A driver feeds load, suspend,
// tick and unknown beats from a queue. A mirror of the task table predicts
// which tasks fire on each tick, and a monitor checks every result beat in
// order. The run steps through several sender and receiver idling mixes.
// ----------------------------------------------------------------------------

module tb_periodic_task_tick_scheduler;

  // Action code that the block must ignore
  localparam logic [ptts_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RESET_CYCLES  = 8;
  localparam int TICK_CYCLES   = ptts_pkg::TASK_COUNT + 2;
  localparam int SETTLE_CYCLES = 2 * TICK_CYCLES;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BEATS   = 102;
  // Most loads use short periods and delays so that tasks fire often
  localparam int SHORT_SPAN    = 12;

  typedef struct packed {
    logic [ptts_pkg::ACTION_W-1:0] action;
    logic [ptts_pkg::INDEX_W-1:0]  idx;
    logic [ptts_pkg::TICKS_W-1:0]  period;
    logic [ptts_pkg::TICKS_W-1:0]  delay;
  } sched_beat_t;

  typedef struct packed {
    logic [ptts_pkg::INDEX_W-1:0] idx;
    logic                         last;
  } fire_t;

  // Clock, reset and block ports; every input starts at a known value
  logic                          clk_i               = 1'b0;
  logic                          rst_ni              = 1'b0;
  logic                          in_valid_i          = 1'b0;
  logic                          in_stall_o;
  logic [ptts_pkg::ACTION_W-1:0] action_i            = '0;
  logic [ptts_pkg::INDEX_W-1:0]  task_index_i        = '0;
  logic [ptts_pkg::TICKS_W-1:0]  period_ticks_i      = '0;
  logic [ptts_pkg::TICKS_W-1:0]  first_delay_ticks_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i         = 1'b0;
  logic [ptts_pkg::INDEX_W-1:0]  fired_task_o;
  logic                          last_of_tick_o;

  // Beats waiting for the driver, and firings waiting for the monitor
  sched_beat_t pending_beats[$];
  fire_t       due_fires[$];
  sched_beat_t drv_next;

  // Mirror of the task table
  logic                             task_armed    [ptts_pkg::TASK_COUNT];
  logic [ptts_pkg::COUNT_WIDTH-1:0] countdown     [ptts_pkg::TASK_COUNT];
  logic [ptts_pkg::COUNT_WIDTH-1:0] reload_period [ptts_pkg::TASK_COUNT];

  // Idling mix of the current phase, in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int fail_count    = 0;
  int beats_taken   = 0;
  int ticks_taken   = 0;
  int fires_checked = 0;
  int quiet_cycles  = 0;

  periodic_task_tick_scheduler uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .task_index_i        (task_index_i),
    .period_ticks_i      (period_ticks_i),
    .first_delay_ticks_i (first_delay_ticks_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .fired_task_o        (fired_task_o),
    .last_of_tick_o      (last_of_tick_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor: apply one accepted beat to the mirrored table and queue the
  // firings that a tick causes, lowest index first, last one flagged.
  // --------------------------------------------------------------------------
  task automatic apply_beat(input sched_beat_t b);
    logic [ptts_pkg::TASK_COUNT-1:0] hit;
    int                              last_hit;
    fire_t                           f;
    hit      = '0;
    last_hit = -1;
    case (b.action)
      ptts_pkg::ACT_LOAD: begin
        if (b.idx < ptts_pkg::TASK_COUNT) begin
          // A zero period would never reload; store it as one tick
          reload_period[b.idx] = (ptts_pkg::COUNT_WIDTH'(b.period) == '0)
                                 ? ptts_pkg::COUNT_WIDTH'(1)
                                 : ptts_pkg::COUNT_WIDTH'(b.period);
          countdown[b.idx]     = ptts_pkg::COUNT_WIDTH'(b.delay);
          task_armed[b.idx]    = 1'b1;
        end
      end
      ptts_pkg::ACT_SUSPEND: begin
        if (b.idx < ptts_pkg::TASK_COUNT) task_armed[b.idx] = 1'b0;
      end
      ptts_pkg::ACT_TICK: begin
        ticks_taken++;
        for (int i = 0; i < ptts_pkg::TASK_COUNT; i++) begin
          if (task_armed[i]) begin
            if (countdown[i] == '0) begin
              hit[i]       = 1'b1;
              last_hit     = i;
              countdown[i] = reload_period[i];
            end
            // Countdown is at least one here, so it cannot wrap
            countdown[i] = countdown[i] - ptts_pkg::COUNT_WIDTH'(1);
          end
        end
        for (int i = 0; i < ptts_pkg::TASK_COUNT; i++) begin
          if (hit[i]) begin
            f.idx  = ptts_pkg::INDEX_W'(i);
            f.last = (i == last_hit);
            due_fires.push_back(f);
          end
        end
      end
      default: ;  // unknown action: no state change, no result
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: advance to the next beat only once the current one is taken,
  // and hold the payload steady while the block stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i          <= 1'b0;
      action_i            <= '0;
      task_index_i        <= '0;
      period_ticks_i      <= '0;
      first_delay_ticks_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_next             = pending_beats.pop_front();
        in_valid_i          <= 1'b1;
        action_i            <= drv_next.action;
        task_index_i        <= drv_next.idx;
        period_ticks_i      <= drv_next.period;
        first_delay_ticks_i <= drv_next.delay;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, drawn fresh every cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats against the oldest expected firing first,
  // then feed the accepted input beat to the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_fires.size() == 0) begin
          $display("%0t: unexpected result beat, fired_task %0d last_of_tick %0b",
                   $time, fired_task_o, last_of_tick_o);
          fail_count++;
        end else begin
          fire_t exp_fire;
          exp_fire = due_fires.pop_front();
          fires_checked++;
          if (fired_task_o !== exp_fire.idx) begin
            $display("%0t: fired_task expected %0d, got %0d",
                     $time, exp_fire.idx, fired_task_o);
            fail_count++;
          end
          if (last_of_tick_o !== exp_fire.last) begin
            $display("%0t: last_of_tick expected %0b, got %0b (task %0d)",
                     $time, exp_fire.last, last_of_tick_o, exp_fire.idx);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        beats_taken++;
        apply_beat({action_i, task_index_i, period_ticks_i, first_delay_ticks_i});
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d firings still due",
                 $time, quiet_cycles, due_fires.size());
        $display("periodic_task_tick_scheduler regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic sched_beat_t make_beat(input logic [ptts_pkg::ACTION_W-1:0] action,
                                            input int idx, input int period,
                                            input int delay);
    sched_beat_t b;
    b.action = action;
    b.idx    = ptts_pkg::INDEX_W'(idx);
    b.period = ptts_pkg::TICKS_W'(period);
    b.delay  = ptts_pkg::TICKS_W'(delay);
    return b;
  endfunction

  // Mostly ticks and short loads; suspends and unknown beats as noise.
  // Unused fields carry random junk that the block must ignore.
  task automatic fill_random(input int count);
    sched_beat_t b;
    int          roll;
    repeat (count) begin
      roll     = $urandom_range(99);
      b.idx    = ptts_pkg::INDEX_W'($urandom_range(ptts_pkg::TASK_COUNT - 1));
      b.period = ptts_pkg::TICKS_W'($urandom);
      b.delay  = ptts_pkg::TICKS_W'($urandom);
      if (roll < 55) begin
        b.action = ptts_pkg::ACT_TICK;
      end else if (roll < 82) begin
        b.action = ptts_pkg::ACT_LOAD;
        // Keep most loads short; the rest park a task far out
        if ($urandom_range(99) < 85) begin
          b.period = ptts_pkg::TICKS_W'($urandom_range(SHORT_SPAN));
          b.delay  = ptts_pkg::TICKS_W'($urandom_range(SHORT_SPAN));
        end
      end else if (roll < 94) begin
        b.action = ptts_pkg::ACT_SUSPEND;
      end else begin
        b.action = ACT_UNUSED;
      end
      pending_beats.push_back(b);
    end
  endtask

  // Set the idling mix, queue a batch of random beats and drain it
  task automatic run_phase(input int send_pct, input int stall_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    fill_random(PHASE_BEATS);
    while (pending_beats.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    foreach (task_armed[i]) task_armed[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, ignored action, zero period, extremes,
    // suspend and reload, and every task due on the same tick.
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    0, 16'hffff, 16'hffff));
    pending_beats.push_back(make_beat(ACT_UNUSED,            5, 16'h5a5a, 16'ha5a5));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_LOAD,    0, 0, 0));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_LOAD,    7, 16'hffff, 16'hffff));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_LOAD,    3, 2, 1));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    0, 0, 0));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    7, 16'haaaa, 16'h5555));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    0, 0, 0));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_SUSPEND, 0, 16'h5555, 16'haaaa));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    0, 0, 0));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_SUSPEND, 6, 0, 0));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_LOAD,    0, 3, 0));
    for (int i = 1; i < ptts_pkg::TASK_COUNT; i++) begin
      pending_beats.push_back(make_beat(ptts_pkg::ACT_LOAD, i, i % 2, 0));
    end
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    0, 0, 0));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    0, 0, 0));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_SUSPEND, 7, 16'hffff, 16'hffff));
    pending_beats.push_back(make_beat(ptts_pkg::ACT_TICK,    0, 0, 0));
    while (pending_beats.size() != 0) @(negedge clk_i);

    // Random part over four idling mixes
    run_phase(0, 0);
    run_phase(55, 0);
    run_phase(0, 55);
    run_phase(17, 17);

    // Drain, then give the block time to show any stray result
    while (pending_beats.size() != 0 || in_valid_i || due_fires.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("Covered %0d input beats including %0d ticks; %0d fired tasks checked",
             beats_taken, ticks_taken, fires_checked);
    $display("over free-running, sender-idle, receiver-stall and mixed phases.");
    if (fail_count == 0) begin
      $display("periodic_task_tick_scheduler regression: pass");
    end else begin
      $display("periodic_task_tick_scheduler regression: fail");
    end
    $finish;
  end

endmodule

### periodic_task_tick_scheduler.f
+incdir+src
src/ptts_pkg.sv
src/ptts_task_table.sv
src/ptts_out_stage.sv
src/ptts_sequencer.sv
src/periodic_task_tick_scheduler.sv
tb/tb_periodic_task_tick_scheduler.sv
